// ===== rtl/core/slab_object_allocator_unit_assert.svh =====
// Assertion macros used by the checker file (soa_checker).
// Each macro expands to one labeled concurrent assertion clocked on the
// rising edge and disabled while the active-low reset is asserted.
`ifndef SLAB_OBJECT_ALLOCATOR_UNIT_ASSERT_SVH
`define SLAB_OBJECT_ALLOCATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SOA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slab allocator assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SOA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slab allocator assertion failed");

`endif

// ===== rtl/core/soa_pkg.sv =====
// ---------------------------------------------------------------------------
// soa_pkg
// Shared types and codes of the slab object allocator.
// ---------------------------------------------------------------------------
package soa_pkg;

    localparam int ADDR_W = 32;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic
    {
        MODE_ALLOC   = 1'b0,
        MODE_RELEASE = 1'b1
    } mode_t;

    typedef enum logic [1:0]
    {
        STATUS_OK           = 2'd0,
        STATUS_OUT_OF_MEM   = 2'd1,
        STATUS_INVALID_ADDR = 2'd2,
        STATUS_ALREADY_FREE = 2'd3
    } status_t;

endpackage

// ===== rtl/core/soa_ifs.sv =====
// ---------------------------------------------------------------------------
// soa_ifs
// Valid/ready channel interfaces: request, response and configuration.
// ---------------------------------------------------------------------------
interface soa_req_if;
    logic           valid;
    logic           ready;
    soa_pkg::mode_t mode;
    soa_pkg::addr_t release_address;

    modport source (output valid, output mode, output release_address, input ready);
    modport sink   (input valid, input mode, input release_address, output ready);
endinterface

interface soa_rsp_if;
    logic             valid;
    logic             ready;
    soa_pkg::status_t status;
    soa_pkg::addr_t   object_address;

    modport source (output valid, output status, output object_address, input ready);
    modport sink   (input valid, input status, input object_address, output ready);
endinterface

interface soa_cfg_if;
    logic           valid;
    logic           ready;
    soa_pkg::addr_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/soa_ram.sv =====
// ---------------------------------------------------------------------------
// soa_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ---------------------------------------------------------------------------
module soa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/slab_object_allocator_unit.sv =====
// ---------------------------------------------------------------------------
// slab_object_allocator_unit
// Bitmap slab allocator: hands out and takes back fixed-size objects.
// ---------------------------------------------------------------------------
// Usage:
//   req : one transaction per allocate (mode 0) or release (mode 1, with
//         release_address). rsp: exactly one transaction per request,
//         carrying status and, for a good allocate, the object address.
//   cfg : writes region_base; write only while no request is in flight.
// Timing: on accept (ST_IDLE) the unit picks the slab (priority encode of
//   the partial/empty masks, or address decode) and issues the read of that
//   slab's bitmap entry. In ST_EXEC it picks the object, writes the entry
//   back and loads the response register. Because of the read-modify-write
//   of the slab RAM, no new request is accepted until ST_EXEC is done.
// Stall: the response register lets the next request be accepted while a
//   response waits; that request then holds in ST_EXEC until the
//   response register frees up.
// Reset: all slabs empty. Per-slab init bits make unwritten RAM entries read
//   as "all objects free", so no clearing pass is needed.
// ---------------------------------------------------------------------------
module slab_object_allocator_unit #(
    parameter int NUM_SLABS        = 16,
    parameter int OBJECTS_PER_SLAB = 15,
    parameter int OBJECT_BYTES     = 256,
    parameter int SLAB_BYTES       = 4096
) (
    input  logic      clk,
    input  logic      rst_n,
    soa_req_if.sink   req,
    soa_rsp_if.source rsp,
    soa_cfg_if.sink   cfg
);

    localparam int SLAB_W     = $clog2(NUM_SLABS);
    localparam int OBJ_W      = $clog2(OBJECTS_PER_SLAB);
    localparam int CNT_W      = $clog2(OBJECTS_PER_SLAB + 1);
    localparam int SLAB_SHIFT = $clog2(SLAB_BYTES);
    localparam int OBJ_SHIFT  = $clog2(OBJECT_BYTES);
    localparam int BLK_W      = SLAB_SHIFT - OBJ_SHIFT;
    localparam int ENTRY_W    = CNT_W + OBJECTS_PER_SLAB;
    localparam logic [32:0] REGION_BYTES = 33'(NUM_SLABS * SLAB_BYTES);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(OBJECTS_PER_SLAB);
    localparam logic [ENTRY_W-1:0] RESET_ENTRY = {FULL_CNT, {OBJECTS_PER_SLAB{1'b1}}};

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    soa_pkg::addr_t        base_reg;
    logic [NUM_SLABS-1:0]  slab_init_reg, slab_init_next;
    logic [NUM_SLABS-1:0]  empty_reg, empty_next;
    logic [NUM_SLABS-1:0]  partial_reg, partial_next;

    // request context held from accept into ST_EXEC
    soa_pkg::mode_t        mode_reg, mode_next;
    logic [SLAB_W-1:0]     slab_reg, slab_next;
    logic [OBJ_W-1:0]      rel_obj_reg, rel_obj_next;
    logic                  from_empty_reg, from_empty_next;
    logic                  early_fail_reg, early_fail_next;
    soa_pkg::status_t      early_status_reg, early_status_next;

    logic                  out_valid_reg, out_valid_next;
    soa_pkg::status_t      out_status_reg, out_status_next;
    soa_pkg::addr_t        out_addr_reg, out_addr_next;

    // decode at accept (ST_IDLE)
    logic [NUM_SLABS-1:0]  pool;
    logic [SLAB_W-1:0]     alloc_slab;
    logic                  alloc_found;
    soa_pkg::addr_t        rel_off;
    logic                  rel_in_region;
    logic [BLK_W-1:0]      rel_blk;
    logic                  rel_blk_ok;
    logic [SLAB_W-1:0]     slab_sel;

    // ST_EXEC update
    logic [ENTRY_W-1:0]          ram_rdata, ram_wdata;
    logic                        ram_we;
    logic [SLAB_W-1:0]           ram_raddr;
    logic [ENTRY_W-1:0]          entry;
    logic [OBJECTS_PER_SLAB-1:0] bits, new_bits, obit;
    logic [CNT_W-1:0]            cnt, new_cnt;
    logic [OBJ_W-1:0]            obj_pick;
    logic                        obj_found;
    logic [NUM_SLABS-1:0]        sbit;
    logic                        exec_go;
    logic                        accept;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.object_address = out_addr_reg;

    // ---- slab selection ----
    assign pool = (partial_reg != '0) ? partial_reg : empty_reg;

    always_comb
    begin
        alloc_slab  = '0;
        alloc_found = 1'b0;
        for (int i = NUM_SLABS - 1; i >= 0; i--)
        begin
            if (pool[i])
            begin
                alloc_slab  = SLAB_W'(i);
                alloc_found = 1'b1;
            end
        end
    end

    assign rel_off       = req.release_address - base_reg;
    assign rel_in_region = ({1'b0, rel_off} < REGION_BYTES);
    assign rel_blk       = rel_off[OBJ_SHIFT +: BLK_W];
    assign rel_blk_ok    = (rel_blk != '0) && (32'(rel_blk) <= 32'(OBJECTS_PER_SLAB));
    assign slab_sel      = (req.mode == soa_pkg::MODE_RELEASE)
                         ? rel_off[SLAB_SHIFT +: SLAB_W] : alloc_slab;

    assign ram_raddr = (state_reg == ST_IDLE) ? slab_sel : slab_reg;

    soa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLABS)
    ) u_slab_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slab_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---- object selection and entry update ----
    assign entry = slab_init_reg[slab_reg] ? ram_rdata : RESET_ENTRY;
    assign bits  = entry[OBJECTS_PER_SLAB-1:0];
    assign cnt   = entry[ENTRY_W-1:OBJECTS_PER_SLAB];
    assign sbit  = NUM_SLABS'(1) << slab_reg;
    assign exec_go = (state_reg == ST_EXEC) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        obj_pick  = '0;
        obj_found = 1'b0;
        for (int i = OBJECTS_PER_SLAB - 1; i >= 0; i--)
        begin
            if (bits[i])
            begin
                obj_pick  = OBJ_W'(i);
                obj_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        slab_init_next    = slab_init_reg;
        empty_next        = empty_reg;
        partial_next      = partial_reg;
        mode_next         = mode_reg;
        slab_next         = slab_reg;
        rel_obj_next      = rel_obj_reg;
        from_empty_next   = from_empty_reg;
        early_fail_next   = early_fail_reg;
        early_status_next = early_status_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_status_next   = out_status_reg;
        out_addr_next     = out_addr_reg;
        ram_we            = 1'b0;
        new_bits          = bits;
        new_cnt           = cnt;
        obit              = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next      = ST_EXEC;
                    mode_next       = req.mode;
                    slab_next       = slab_sel;
                    rel_obj_next    = OBJ_W'(rel_blk - BLK_W'(1));
                    from_empty_next = (partial_reg == '0);
                    if (req.mode == soa_pkg::MODE_RELEASE)
                    begin
                        early_fail_next   = !(rel_in_region && rel_blk_ok);
                        early_status_next = soa_pkg::STATUS_INVALID_ADDR;
                    end
                    else
                    begin
                        early_fail_next   = !alloc_found;
                        early_status_next = soa_pkg::STATUS_OUT_OF_MEM;
                    end
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next      = ST_IDLE;
                    out_valid_next  = 1'b1;
                    out_status_next = soa_pkg::STATUS_OK;
                    out_addr_next   = '0;
                    if (early_fail_reg)
                    begin
                        out_status_next = early_status_reg;
                    end
                    else if (mode_reg == soa_pkg::MODE_ALLOC)
                    begin
                        if (!obj_found || cnt == '0)
                        begin
                            out_status_next = soa_pkg::STATUS_OUT_OF_MEM;
                        end
                        else
                        begin
                            obit     = OBJECTS_PER_SLAB'(1) << obj_pick;
                            new_bits = bits & ~obit;
                            new_cnt  = cnt - CNT_W'(1);
                            ram_we   = 1'b1;
                            slab_init_next = slab_init_reg | sbit;
                            if (from_empty_reg)
                            begin
                                empty_next   = empty_next & ~sbit;
                                partial_next = partial_next | sbit;
                            end
                            if (new_cnt == '0)
                            begin
                                partial_next = partial_next & ~sbit;
                            end
                            out_addr_next = base_reg
                                          + (32'(slab_reg) << SLAB_SHIFT)
                                          + ((32'(obj_pick) + 32'd1) << OBJ_SHIFT);
                        end
                    end
                    else
                    begin
                        obit = OBJECTS_PER_SLAB'(1) << rel_obj_reg;
                        if ((bits & obit) != '0)
                        begin
                            out_status_next = soa_pkg::STATUS_ALREADY_FREE;
                        end
                        else
                        begin
                            new_bits = bits | obit;
                            if (cnt < FULL_CNT)
                            begin
                                new_cnt = cnt + CNT_W'(1);
                            end
                            ram_we = 1'b1;
                            slab_init_next = slab_init_reg | sbit;
                            if (new_cnt == CNT_W'(1))
                            begin
                                partial_next = partial_next | sbit;
                            end
                            if (new_cnt == FULL_CNT)
                            begin
                                partial_next = partial_next & ~sbit;
                                empty_next   = empty_next | sbit;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ram_wdata = {new_cnt, new_bits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= '0;
            slab_init_reg <= '0;
            empty_reg     <= '1;
            partial_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slab_init_reg <= slab_init_next;
            empty_reg     <= empty_next;
            partial_reg   <= partial_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                base_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg         <= mode_next;
        slab_reg         <= slab_next;
        rel_obj_reg      <= rel_obj_next;
        from_empty_reg   <= from_empty_next;
        early_fail_reg   <= early_fail_next;
        early_status_reg <= early_status_next;
        out_status_reg   <= out_status_next;
        out_addr_reg     <= out_addr_next;
    end

endmodule

// ===== rtl/core/soa_checker.sv =====
// ---------------------------------------------------------------------------
// soa_checker
// Port-level assertions for the slab allocator, bound into slab_object_allocator_unit.
// ---------------------------------------------------------------------------
`include "slab_object_allocator_unit_assert.svh"

module soa_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [1:0]  rsp_status,
    input  logic [31:0] rsp_object_address
);

    `SOA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `SOA_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_status) && $stable(rsp_object_address))
    // after a request is accepted the engine is busy (ready low)
    `SOA_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready)
    // only a good allocate carries an address
    `SOA_ASSERT_SAME(a_addr_zero_on_fail, clk, rst_n, rsp_valid && (rsp_status != soa_pkg::STATUS_OK), rsp_object_address == 32'd0)

endmodule

bind slab_object_allocator_unit soa_checker u_soa_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_object_address (rsp.object_address)
);

// ===== sim/slab_object_allocator_unit_tb.sv =====
// ---------------------------------------------------------------------------
// slab_object_allocator_unit_tb
// Self-checking bench for the slab allocator. A predictor class tracks the
// per-slab bitmaps, free counts and slab masks, queues the reply due for
// every accepted request and checks replies in order. Stimulus is a short
// directed run followed by fill / churn / drain traffic at several region
// bases, with random gaps on the request side and stalls on the reply side.
// ---------------------------------------------------------------------------
module slab_object_allocator_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLABS        = 16;
    localparam int OBJECTS_PER_SLAB = 15;
    localparam int OBJECT_BYTES     = 256;
    localparam int SLAB_BYTES       = 4096;
    localparam int REGION_BYTES     = NUM_SLABS * SLAB_BYTES;
    localparam int TOTAL_OBJECTS    = NUM_SLABS * OBJECTS_PER_SLAB;
    localparam int QUIET_LIMIT      = 20000;
    localparam int CHUNK_ITEMS      = 255;

    typedef struct packed
    {
        soa_pkg::status_t status;
        soa_pkg::addr_t   object_address;
    } reply_t;

    class slab_alloc_predictor;
        soa_pkg::addr_t              region_base;
        logic [OBJECTS_PER_SLAB-1:0] obj_free [NUM_SLABS];
        int                          free_cnt [NUM_SLABS];
        logic [NUM_SLABS-1:0]        slabs_empty;
        logic [NUM_SLABS-1:0]        slabs_partial;
        logic [NUM_SLABS-1:0]        slabs_full;
        reply_t                      expected_replies [$];
        int mismatches;
        int replies_seen;
        int base_writes;
        int n_alloc_ok;
        int n_oom;
        int n_invalid;
        int n_double;
        int n_release_ok;

        function new();
            region_base   = '0;
            slabs_empty   = '1;
            slabs_partial = '0;
            slabs_full    = '0;
            for (int s = 0; s < NUM_SLABS; s++)
            begin
                obj_free[s] = '1;
                free_cnt[s] = OBJECTS_PER_SLAB;
            end
        endfunction

        function void set_region_base(soa_pkg::addr_t b);
            region_base = b;
            base_writes++;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function void allocate();
            logic [NUM_SLABS-1:0] pool;
            bit                   from_empty;
            int                   slab;
            int                   obj;
            reply_t               r;
            pool       = slabs_partial;
            from_empty = 1'b0;
            slab       = -1;
            obj        = -1;
            if (pool == '0)
            begin
                pool       = slabs_empty;
                from_empty = 1'b1;
            end
            for (int s = NUM_SLABS - 1; s >= 0; s--)
                if (pool[s])
                    slab = s;
            if (slab >= 0)
                for (int k = OBJECTS_PER_SLAB - 1; k >= 0; k--)
                    if (obj_free[slab][k])
                        obj = k;
            if (slab < 0 || obj < 0 || free_cnt[slab] == 0)
            begin
                r.status         = soa_pkg::STATUS_OUT_OF_MEM;
                r.object_address = '0;
                n_oom++;
            end
            else
            begin
                obj_free[slab][obj] = 1'b0;
                free_cnt[slab]--;
                if (from_empty)
                begin
                    slabs_empty[slab]   = 1'b0;
                    slabs_partial[slab] = 1'b1;
                end
                if (free_cnt[slab] == 0)
                begin
                    slabs_partial[slab] = 1'b0;
                    slabs_full[slab]    = 1'b1;
                end
                r.status         = soa_pkg::STATUS_OK;
                r.object_address = region_base + soa_pkg::addr_t'(SLAB_BYTES * slab)
                                 + soa_pkg::addr_t'(OBJECT_BYTES * (obj + 1));
                n_alloc_ok++;
            end
            expected_replies.push_back(r);
        endfunction

        function void release_object(soa_pkg::addr_t a);
            soa_pkg::addr_t off;
            int             slab;
            int             block;
            reply_t         r;
            off              = a - region_base;
            r.object_address = '0;
            slab             = int'(off / SLAB_BYTES);
            block            = int'((off % SLAB_BYTES) / OBJECT_BYTES);
            // header block and anything past the last slab are both invalid
            if (off >= soa_pkg::addr_t'(REGION_BYTES) || block == 0
                || block > OBJECTS_PER_SLAB)
            begin
                r.status = soa_pkg::STATUS_INVALID_ADDR;
                n_invalid++;
            end
            else if (obj_free[slab][block-1])
            begin
                r.status = soa_pkg::STATUS_ALREADY_FREE;
                n_double++;
            end
            else
            begin
                obj_free[slab][block-1] = 1'b1;
                if (free_cnt[slab] < OBJECTS_PER_SLAB)
                    free_cnt[slab]++;
                if (free_cnt[slab] == 1)
                begin
                    slabs_full[slab]    = 1'b0;
                    slabs_partial[slab] = 1'b1;
                end
                if (free_cnt[slab] == OBJECTS_PER_SLAB)
                begin
                    slabs_partial[slab] = 1'b0;
                    slabs_empty[slab]   = 1'b1;
                end
                r.status = soa_pkg::STATUS_OK;
                n_release_ok++;
            end
            expected_replies.push_back(r);
        endfunction

        function void note_request(soa_pkg::mode_t m, soa_pkg::addr_t a);
            if (m == soa_pkg::MODE_ALLOC)
                allocate();
            else
                release_object(a);
        endfunction

        function void check_reply(soa_pkg::status_t s, soa_pkg::addr_t a);
            reply_t e;
            replies_seen++;
            if (expected_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: reply with none due: status %0d addr %08h",
                             $realtime, s, a);
                return;
            end
            e = expected_replies.pop_front();
            if (s !== e.status || a !== e.object_address)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: reply mismatch: expected status %0d addr %08h, %s %0d %s %08h",
                             $realtime, e.status, e.object_address,
                             "got status", s, "addr", a);
            end
        endfunction

        // Block-aligned address of a random object that is free (or in use).
        function bit pick_object(bit want_free, output soa_pkg::addr_t a);
            int start;
            int idx;
            start = $urandom_range(TOTAL_OBJECTS - 1);
            a     = '0;
            for (int i = 0; i < TOTAL_OBJECTS; i++)
            begin
                idx = (start + i) % TOTAL_OBJECTS;
                if (obj_free[idx / OBJECTS_PER_SLAB][idx % OBJECTS_PER_SLAB] == want_free)
                begin
                    a = region_base
                      + soa_pkg::addr_t'(SLAB_BYTES * (idx / OBJECTS_PER_SLAB))
                      + soa_pkg::addr_t'(OBJECT_BYTES * (idx % OBJECTS_PER_SLAB + 1));
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction
    endclass

    logic clk;
    logic rst_n;

    soa_req_if req_ch ();
    soa_rsp_if rsp_ch ();
    soa_cfg_if cfg_ch ();

    slab_object_allocator_unit u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    slab_alloc_predictor predictor = new();

    int req_gap_pct;
    int rsp_stall_pct;
    int quiet_cycles;
    int traffic_left;
    int alloc_pct;
    int traffic_phase;
    int requests_sent;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // reply side back-pressure
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready)
            predictor.check_reply(rsp_ch.status, rsp_ch.object_address);
        if (req_ch.valid && req_ch.ready)
            predictor.note_request(req_ch.mode, req_ch.release_address);
        if (cfg_ch.valid && cfg_ch.ready)
            predictor.set_region_base(cfg_ch.data);
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_request(soa_pkg::mode_t m, soa_pkg::addr_t a);
        while ($urandom_range(99) < req_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.mode            <= m;
        req_ch.release_address <= a;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic drain_replies();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (predictor.pending() != 0)
            @(negedge clk);
    endtask

    // region_base may only change with nothing in flight
    task automatic program_base(soa_pkg::addr_t b);
        drain_replies();
        repeat (4) @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= b;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_request();
        soa_pkg::addr_t a;
        int             pick;
        if (traffic_left == 0)
        begin
            // cycle fill -> churn -> drain so the pool runs full and empty again
            traffic_phase = (traffic_phase + 1) % 3;
            alloc_pct     = (traffic_phase == 0) ? 90 : (traffic_phase == 1) ? 50 : 15;
            traffic_left  = $urandom_range(350, 150);
        end
        traffic_left--;
        if ($urandom_range(99) < alloc_pct)
        begin
            send_request(soa_pkg::MODE_ALLOC, soa_pkg::addr_t'($urandom));
            return;
        end
        pick = $urandom_range(99);
        if (pick < 70 && predictor.pick_object(1'b0, a))
            a = a + soa_pkg::addr_t'($urandom_range(OBJECT_BYTES - 1));
        else if (pick < 80 && predictor.pick_object(1'b1, a))
            a = a + soa_pkg::addr_t'($urandom_range(OBJECT_BYTES - 1));
        else if (pick < 88)
            a = predictor.region_base
              + soa_pkg::addr_t'(SLAB_BYTES * $urandom_range(NUM_SLABS - 1))
              + soa_pkg::addr_t'($urandom_range(OBJECT_BYTES - 1));
        else if (pick < 94)
            a = predictor.region_base + soa_pkg::addr_t'(REGION_BYTES)
              + soa_pkg::addr_t'($urandom_range(32'hFFFF_FFFF - REGION_BYTES));
        else
            a = soa_pkg::addr_t'($urandom);
        send_request(soa_pkg::MODE_RELEASE, a);
    endtask

    task automatic run_chunk(soa_pkg::addr_t b, int gap, int stall);
        program_base(b);
        req_gap_pct   = gap;
        rsp_stall_pct = stall;
        for (int i = 0; i < CHUNK_ITEMS; i++)
        begin
            if ($urandom_range(99) == 0)
                drain_replies();
            random_request();
        end
    endtask

    initial
    begin
        req_ch.valid           <= 1'b0;
        req_ch.mode            <= soa_pkg::MODE_ALLOC;
        req_ch.release_address <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.data            <= '0;
        rst_n                  <= 1'b0;
        req_gap_pct   = 0;
        rsp_stall_pct = 0;
        traffic_left  = 0;
        traffic_phase = 2;
        alloc_pct     = 50;
        requests_sent = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: region at zero
        program_base(32'h0000_0000);
        req_gap_pct   = 24;
        rsp_stall_pct = 61;
        send_request(soa_pkg::MODE_RELEASE, 32'h0000_0100);  // never allocated
        send_request(soa_pkg::MODE_RELEASE, 32'h0000_0000);  // header block
        send_request(soa_pkg::MODE_RELEASE, 32'h0000_00FF);
        send_request(soa_pkg::MODE_RELEASE, 32'h0001_0000);  // just past the region
        send_request(soa_pkg::MODE_RELEASE, 32'hFFFF_FFFF);
        send_request(soa_pkg::MODE_ALLOC, 32'hFFFF_FFFF);
        send_request(soa_pkg::MODE_ALLOC, 32'h0000_0000);
        send_request(soa_pkg::MODE_ALLOC, 32'hAAAA_5555);
        send_request(soa_pkg::MODE_RELEASE, 32'h0000_02FF);
        send_request(soa_pkg::MODE_RELEASE, 32'h0000_0200);  // double free
        send_request(soa_pkg::MODE_ALLOC, 32'h5555_AAAA);
        send_request(soa_pkg::MODE_RELEASE, 32'h0000_FFFF);  // last block of last slab
        send_request(soa_pkg::MODE_RELEASE, 32'h0000_F0F0);  // header of last slab
        send_request(soa_pkg::MODE_RELEASE, 32'h0000_0100);
        send_request(soa_pkg::MODE_RELEASE, 32'h0000_0200);
        send_request(soa_pkg::MODE_RELEASE, 32'h0000_0300);

        // directed: region wrapping past the top of the address space
        program_base(32'hFFFF_F800);
        for (int i = 0; i < 8; i++)
            send_request(soa_pkg::MODE_ALLOC, '0);
        send_request(soa_pkg::MODE_RELEASE, 32'h0000_0000);
        send_request(soa_pkg::MODE_RELEASE, 32'hFFFF_F7FF);  // offset wraps out of range

        run_chunk(32'h0000_0000, 24, 61);
        run_chunk(32'hFFFF_FFFF, 24, 61);
        run_chunk(soa_pkg::addr_t'($urandom), 61, 24);
        run_chunk(32'hFFFF_8000, 61, 24);
        run_chunk(32'h8000_0100, 0, 0);
        run_chunk(soa_pkg::addr_t'($urandom), 0, 0);

        drain_replies();
        repeat (8) @(negedge clk);

        $display("Covered %0d requests, %0d replies, %0d region_base writes.",
                 requests_sent, predictor.replies_seen, predictor.base_writes);
        $display("Allocs ok %0d, out of memory %0d, releases ok %0d, invalid %0d, %s %0d.",
                 predictor.n_alloc_ok, predictor.n_oom, predictor.n_release_ok,
                 predictor.n_invalid, "double free", predictor.n_double);
        if (predictor.mismatches == 0 && predictor.pending() == 0)
            $display("[ OK ] regression clean");
        else
        begin
            $display("%0d mismatches, %0d replies missing", predictor.mismatches,
                     predictor.pending());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
